@@ sv/swfr_pkg.sv @@
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared constants, status codes and result type of the sync word frame
// reassembler.
// ----------------------------------------------------------------------------
package swfr_pkg;

  // field widths of the ports
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int OFFSET_W = 12;
  localparam int FLEN_W   = 13;
  localparam int LEN_W    = 32;

  // default structure of a frame
  localparam int HEADER_BYTES_DEF   = 40;
  localparam int FRAME_CAPACITY_DEF = 4096;
  localparam logic [FLEN_W-1:0] MAX_FRAME_RST = FLEN_W'(4096);

  // sync word and the place of the length field
  localparam int SYNC_LEN      = 8;
  localparam int PROG_W        = $clog2(SYNC_LEN);
  localparam int LEN_FIELD_POS = 12;
  localparam int LEN_FIELD_LEN = 4;

  localparam logic [BYTE_W-1:0] SYNC_WORD [SYNC_LEN] = '{
    8'd2, 8'd1, 8'd4, 8'd3, 8'd6, 8'd5, 8'd8, 8'd7
  };

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HUNTING  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SYNCED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
    logic [BYTE_W-1:0]   data_byte;
    logic [FLEN_W-1:0]   frame_length;
  } swfr_result_t;

endpackage

@@ sv/swfr_parser.sv @@
// ----------------------------------------------------------------------------
// swfr_parser
// Frame tracking state (sync progress, byte count, declared length) and the
// decode of one received byte into its result, one byte per enabled cycle.
// ----------------------------------------------------------------------------
module swfr_parser #(
  parameter int HEADER_BYTES   = swfr_pkg::HEADER_BYTES_DEF,
  parameter int FRAME_CAPACITY = swfr_pkg::FRAME_CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [swfr_pkg::BYTE_W-1:0]    rx_byte,
  input  logic [swfr_pkg::FLEN_W-1:0]    max_frame,
  output swfr_pkg::swfr_result_t         result
);
  import swfr_pkg::*;

  localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);

  logic [PROG_W-1:0] prog_r, prog_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  logic [CNT_W-1:0]  cnt_inc;
  logic [LEN_W-1:0]  pos_ext;
  logic [LEN_W-1:0]  lane_ofs;
  logic [1:0]        lane;
  logic [LEN_W-1:0]  len_upd;
  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  cnt_inc_ext;

  // length limit is the smaller of the register and the capacity
  assign limit = (LEN_W'(max_frame) > LEN_W'(FRAME_CAPACITY)) ?
                 LEN_W'(FRAME_CAPACITY) : LEN_W'(max_frame);

  assign cnt_inc     = cnt_r + CNT_W'(1);
  assign cnt_inc_ext = LEN_W'(cnt_inc);
  assign pos_ext     = LEN_W'(cnt_r);
  assign lane_ofs    = pos_ext - LEN_W'(LEN_FIELD_POS);
  assign lane        = lane_ofs[1:0];

  // gather the little-endian length field
  always_comb begin
    len_upd = len_r;
    if (pos_ext >= LEN_W'(LEN_FIELD_POS) &&
        pos_ext < LEN_W'(LEN_FIELD_POS + LEN_FIELD_LEN)) begin
      len_upd[{lane, 3'b000} +: BYTE_W] = len_r[{lane, 3'b000} +: BYTE_W] | rx_byte;
    end
  end

  // decode of one byte
  always_comb begin
    prog_nxt = prog_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    result   = '0;
    if (cnt_r == '0) begin
      // hunting for the sync word
      result.status = ST_HUNTING;
      if (rx_byte == SYNC_WORD[prog_r]) begin
        if (prog_r == PROG_W'(SYNC_LEN - 1)) begin
          prog_nxt      = '0;
          cnt_nxt       = CNT_W'(SYNC_LEN);
          len_nxt       = '0;
          result.status = ST_SYNCED;
        end else begin
          prog_nxt = prog_r + PROG_W'(1);
        end
      end else begin
        prog_nxt = (rx_byte == SYNC_WORD[0]) ? PROG_W'(1) : '0;
      end
    end else begin
      // in a frame: every byte is reported at its offset
      result.offset    = OFFSET_W'(cnt_r);
      result.data_byte = rx_byte;
      result.status    = ST_STORED;
      cnt_nxt          = cnt_inc;
      len_nxt          = len_upd;
      if (cnt_inc_ext == LEN_W'(HEADER_BYTES) &&
          (len_upd < LEN_W'(HEADER_BYTES) || len_upd > limit)) begin
        result.status = ST_DROPPED;
        prog_nxt      = '0;
        cnt_nxt       = '0;
        len_nxt       = '0;
      end else if (cnt_inc_ext >= LEN_W'(HEADER_BYTES) && cnt_inc_ext >= len_upd) begin
        result.status       = ST_COMPLETE;
        result.frame_length = FLEN_W'(len_upd);
        prog_nxt            = '0;
        cnt_nxt             = '0;
        len_nxt             = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r <= '0;
      cnt_r  <= '0;
      len_r  <= '0;
    end else if (step) begin
      prog_r <= prog_nxt;
      cnt_r  <= cnt_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

@@ sv/sync_word_frame_reassembler.sv @@
// The result passes through the input register and then the result register,
// and the result register holds while out_stall is high; throughput is one
// byte per cycle while the output does not stall, set by the single decode
// pass between the two registers.
// Reset (rst_n low, synchronous) clears both stages, returns to hunting and
// sets max_frame to 4096.
// ----------------------------------------------------------------------------
// sync_word_frame_reassembler
// Hunts for the 8-byte sync word, then reports each frame byte at its offset,
// checks the declared length after the header and marks frame completion.
// ----------------------------------------------------------------------------
module sync_word_frame_reassembler #(
  parameter int HEADER_BYTES   = swfr_pkg::HEADER_BYTES_DEF,
  parameter int FRAME_CAPACITY = swfr_pkg::FRAME_CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [swfr_pkg::FLEN_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [swfr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [swfr_pkg::STATUS_W-1:0]  out_status,
  output logic [swfr_pkg::OFFSET_W-1:0]  out_offset,
  output logic [swfr_pkg::BYTE_W-1:0]    out_data_byte,
  output logic [swfr_pkg::FLEN_W-1:0]    out_frame_length
);
  import swfr_pkg::*;

  logic [FLEN_W-1:0] max_frame_r;
  logic              in_vld_r, in_vld_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              out_vld_r, out_vld_nxt;
  swfr_result_t      res_r;
  swfr_result_t      res;
  logic              out_load;
  logic              in_load;
  logic              step;

  // handshake between the stages
  assign out_load    = !out_vld_r || !out_stall;
  assign step        = in_vld_r && out_load;
  assign in_load     = !in_vld_r || out_load;
  assign in_stall    = !in_load;
  assign in_vld_nxt  = in_load ? in_valid : in_vld_r;
  assign out_vld_nxt = out_load ? step : out_vld_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= MAX_FRAME_RST;
    end else if (cfg_wr_en) begin
      max_frame_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_load) begin
      byte_r <= in_rx_byte;
    end
  end

  swfr_parser #(
    .HEADER_BYTES   (HEADER_BYTES),
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (byte_r),
    .max_frame (max_frame_r),
    .result    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = res_r.status;
  assign out_offset       = res_r.offset;
  assign out_data_byte    = res_r.data_byte;
  assign out_frame_length = res_r.frame_length;

endmodule
